[hw/rtl/cgk_pkg.sv]
// Shared types, constants and helpers for the keyframe colour ramp.
`default_nettype none
package cgk_pkg;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_EVAL  = 1'b1
  } action_t;

  localparam logic CFG_KEY_COUNT = 1'b0;
  localparam logic CFG_DEFAULT   = 1'b1;

  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [16:0] MIN_SEG_LEN = 17'd65;
  localparam logic [17:0] TIME_CLAMP  = 18'd131072;

  // in_tdata layout, lowest bit first
  localparam int OFS_KIDX  = 0;
  localparam int OFS_KTIME = 4;
  localparam int OFS_KMIN  = 21;
  localparam int OFS_KMAX  = 53;
  localparam int OFS_AGE   = 85;
  localparam int OFS_LIFE  = 109;
  localparam int OFS_RMIX  = 133;
  localparam int IN_DW     = 152;
  localparam int OUT_DW    = 40;

  function automatic logic [23:0] mul8x17(input logic [7:0] a, input logic [16:0] w);
    logic [24:0] p;
    p = {17'b0, a} * {8'b0, w};
    return p[23:0];
  endfunction

  function automatic logic [39:0] mul24x17(input logic [23:0] a, input logic [16:0] w);
    logic [40:0] p;
    p = {17'b0, a} * {24'b0, w};
    return p[39:0];
  endfunction

endpackage
`default_nettype wire

[hw/rtl/color_gradient_keyframe_eval_top.sv]
// Keyframe colour ramp: key table load and pipelined colour evaluation.
//
// Input stream: in_tuser selects a key write or an evaluate request; in_tdata
// carries the key fields or age, lifetime and random mix. A key write stores
// one key and yields no output; an evaluate request yields one output
// request with the colour (bits 31:0) and a hit flag (bit 32).
// Configuration: cfg_we with cfg_index 0 sets the key count, 1 the default
// colour; write only while the pipeline is empty.
// Requests pass through two 17-stage pipelined dividers (relative time, then
// segment blend), the key search, the key memory read and two multiply stages.
// One request is taken per cycle while the receiver does not stall. Key
// writes commit at the search stage in request order, so an evaluate sees
// exactly the keys written before it.
// When the receiver stalls the whole pipeline holds; in_tready follows
// out_tready while an output is pending. Synchronous reset empties the
// pipeline, sets key count 0 and default colour to white; the key table
// itself is not cleared.
`default_nettype none
module color_gradient_keyframe_eval_top #(
  parameter int MAX_KEYS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  // key_index, key_time, key_min_color, key_max_color, age, life_time,
  // random_mix, zero pad
  input  wire logic [cgk_pkg::IN_DW-1:0] in_tdata,
  // action
  input  wire logic                     in_tuser,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  // color, hit, zero pad
  output logic [cgk_pkg::OUT_DW-1:0]    out_tdata,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [31:0]              cfg_data
);

  localparam int IW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int NS  = MAX_KEYS - 1;
  localparam int PW1 = 105;
  localparam int PW2 = 147;

  logic        en;
  logic [4:0]  key_count_r;
  logic [31:0] default_r;
  logic        out_vld_r;
  logic [31:0] out_color_r;
  logic        out_hit_r;

  assign en        = !out_vld_r || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_count_r <= 5'd0;
      default_r   <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cgk_pkg::CFG_KEY_COUNT: key_count_r <= cfg_data[4:0];
        cgk_pkg::CFG_DEFAULT:   default_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Relative time divider
  logic [23:0]     age, life;
  logic            over, life0;
  logic [PW1-1:0]  pay1_in, pay1_out;
  logic            d1_vld;
  logic [16:0]     d1_quo;

  assign age   = in_tdata[cgk_pkg::OFS_AGE +: 24];
  assign life  = in_tdata[cgk_pkg::OFS_LIFE +: 24];
  assign over  = ({1'b0, age} >= {life, 1'b0});
  assign life0 = (life == 24'd0);
  assign pay1_in = {in_tuser, over, life0, in_tdata[cgk_pkg::OFS_RMIX +: 17],
                    in_tdata[cgk_pkg::OFS_KIDX +: 4], in_tdata[cgk_pkg::OFS_KTIME +: 17],
                    in_tdata[cgk_pkg::OFS_KMIN +: 32], in_tdata[cgk_pkg::OFS_KMAX +: 32]};

  cgk_div #(.DW(24), .QW(17), .PW(PW1)) u_div_time (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_tvalid),
    .in_rem  (over ? 24'd0 : {1'b0, age[23:1]}),
    .in_bits ({age[0], 16'b0}),
    .in_div  (life),
    .in_pay  (pay1_in),
    .out_vld (d1_vld),
    .out_quo (d1_quo),
    .out_pay (pay1_out)
  );

  // Search stage: key writes commit here
  logic        m_act, m_over, m_life0;
  logic [16:0] m_rmix, m_ktime;
  logic [3:0]  m_kidx;
  logic [31:0] m_kmin, m_kmax;
  logic [17:0] m_t;
  logic [7:0]  cnt;
  logic        wr_commit;
  logic [NS-1:0] m_match;

  assign {m_act, m_over, m_life0, m_rmix, m_kidx, m_ktime, m_kmin, m_kmax} = pay1_out;
  assign m_t = m_over ? cgk_pkg::TIME_CLAMP : {1'b0, d1_quo};
  assign cnt = (8'(key_count_r) > 8'(MAX_KEYS)) ? 8'(MAX_KEYS) : 8'(key_count_r);
  assign wr_commit = en && d1_vld && (cgk_pkg::action_t'(m_act) == cgk_pkg::ACT_WRITE)
                     && (8'(m_kidx) < 8'(MAX_KEYS));

  logic [16:0] key_time_r [MAX_KEYS];
  logic [80:0] mem_a_r [MAX_KEYS];
  logic [80:0] mem_b_r [MAX_KEYS];

  for (genvar n = 0; n < NS; n++) begin : g_match
    assign m_match[n] = !m_life0 && (8'(n + 1) < cnt) &&
                        ({1'b0, key_time_r[n]} <= m_t) && (m_t <= {1'b0, key_time_r[n+1]});
  end

  always_ff @(posedge clk) begin
    if (wr_commit) begin
      key_time_r[IW'(m_kidx)] <= m_ktime;
      mem_a_r[IW'(m_kidx)]    <= {m_ktime, m_kmin, m_kmax};
      mem_b_r[IW'(m_kidx)]    <= {m_ktime, m_kmin, m_kmax};
    end
  end

  logic          e_vld_r;
  logic [NS-1:0] e_match_r;
  logic [17:0]   e_t_r;
  logic [16:0]   e_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (en) begin
      e_vld_r <= d1_vld && (cgk_pkg::action_t'(m_act) == cgk_pkg::ACT_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_match_r <= m_match;
      e_t_r     <= m_t;
      e_r_r     <= (m_rmix > cgk_pkg::ONE_Q16) ? cgk_pkg::ONE_Q16 : m_rmix;
    end
  end

  // Encode first matching segment and read its two keys
  logic [IW-1:0] e_sel;
  always_comb begin
    e_sel = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (e_match_r[i]) e_sel = IW'(i);
    end
  end

  logic        f_vld_r, f_hit_r;
  logic [17:0] f_t_r;
  logic [16:0] f_r_r;
  logic [80:0] rd_a_r, rd_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= e_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_hit_r <= |e_match_r;
      f_t_r   <= e_t_r;
      f_r_r   <= e_r_r;
      rd_a_r  <= mem_a_r[e_sel];
      rd_b_r  <= mem_b_r[e_sel + IW'(1)];
    end
  end

  // Blend divider
  logic [16:0] f_from, f_to, f_x, f_d;
  logic        f_big;
  logic [PW2-1:0] pay2_in, pay2_out;
  logic        d2_vld;
  logic [16:0] d2_quo;

  assign f_from = rd_a_r[80:64];
  assign f_to   = rd_b_r[80:64];
  assign f_x    = f_t_r[16:0] - f_from;
  assign f_d    = f_to - f_from;
  assign f_big  = f_hit_r && (f_d > cgk_pkg::MIN_SEG_LEN);
  assign pay2_in = {f_hit_r, f_big, f_r_r, rd_a_r[63:32], rd_b_r[63:32],
                    rd_a_r[31:0], rd_b_r[31:0]};

  cgk_div #(.DW(17), .QW(17), .PW(PW2)) u_div_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (f_vld_r),
    .in_rem  (f_big ? {1'b0, f_x[16:1]} : 17'd0),
    .in_bits (f_big ? {f_x[0], 16'b0} : 17'd0),
    .in_div  (f_big ? f_d : 17'd1),
    .in_pay  (pay2_in),
    .out_vld (d2_vld),
    .out_quo (d2_quo),
    .out_pay (pay2_out)
  );

  logic        g_hit, g_big;
  logic [16:0] g_r, g_bk, g_bkn;
  logic [31:0] g_min_a, g_min_b, g_max_a, g_max_b;

  assign {g_hit, g_big, g_r, g_min_a, g_min_b, g_max_a, g_max_b} = pay2_out;
  assign g_bk  = g_big ? d2_quo : 17'd0;
  assign g_bkn = cgk_pkg::ONE_Q16 - g_bk;

  // Key blend products per channel
  logic        l1_vld_r, l1_hit_r;
  logic [16:0] l1_r_r;
  logic [23:0] l1_p_r [4][4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_vld_r <= 1'b0;
    end else if (en) begin
      l1_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l1_hit_r <= g_hit;
      l1_r_r   <= g_r;
      for (int c = 0; c < 4; c++) begin
        l1_p_r[c][0] <= cgk_pkg::mul8x17(g_min_a[8*c +: 8], g_bkn);
        l1_p_r[c][1] <= cgk_pkg::mul8x17(g_min_b[8*c +: 8], g_bk);
        l1_p_r[c][2] <= cgk_pkg::mul8x17(g_max_a[8*c +: 8], g_bkn);
        l1_p_r[c][3] <= cgk_pkg::mul8x17(g_max_b[8*c +: 8], g_bk);
      end
    end
  end

  // Random mix products per channel
  logic        l2_vld_r, l2_hit_r;
  logic [39:0] l2_p_r [4][2];
  logic [16:0] l1_rn;

  assign l1_rn = cgk_pkg::ONE_Q16 - l1_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l2_vld_r <= 1'b0;
    end else if (en) begin
      l2_vld_r <= l1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l2_hit_r <= l1_hit_r;
      for (int c = 0; c < 4; c++) begin
        l2_p_r[c][0] <= cgk_pkg::mul24x17(l1_p_r[c][0] + l1_p_r[c][1], l1_rn);
        l2_p_r[c][1] <= cgk_pkg::mul24x17(l1_p_r[c][2] + l1_p_r[c][3], l1_r_r);
      end
    end
  end

  // Round once, half up, then pick default on a miss
  logic [31:0] mix_color;
  always_comb begin
    logic [39:0] sum;
    mix_color = '0;
    for (int c = 0; c < 4; c++) begin
      sum = l2_p_r[c][0] + l2_p_r[c][1] + 40'h00_8000_0000;
      mix_color[8*c +: 8] = sum[39:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= l2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_color_r <= l2_hit_r ? mix_color : default_r;
      out_hit_r   <= l2_hit_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'b0, out_hit_r, out_color_r};

`ifndef SYNTHESIS
  a_miss_default: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_hit_r) |-> (out_color_r == default_r))
    else $error("miss does not return the default colour");

  a_hit_needs_keys: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_hit_r) |-> (cnt >= 8'd2))
    else $error("hit with fewer than two keys");

  a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready) |=> ($stable(l2_vld_r) && $stable(e_vld_r)))
    else $error("pipeline moved during a stall");
`endif

endmodule
`default_nettype wire

[hw/rtl/cgk_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with side payload.
`default_nettype none
module cgk_div #(
  parameter int DW = 24,
  parameter int QW = 17,
  parameter int PW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  wire logic [DW-1:0] in_rem,
  input  wire logic [QW-1:0] in_bits,
  input  wire logic [DW-1:0] in_div,
  input  wire logic [PW-1:0] in_pay,
  output logic               out_vld,
  output logic [QW-1:0]      out_quo,
  output logic [PW-1:0]      out_pay
);

  logic          vld_r  [QW+1];
  logic [DW-1:0] rem_r  [QW+1];
  logic [QW-1:0] bits_r [QW+1];
  logic [DW-1:0] div_r  [QW+1];
  logic [QW-1:0] quo_r  [QW+1];
  logic [PW-1:0] pay_r  [QW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= in_rem;
      bits_r[0] <= in_bits;
      div_r[0]  <= in_div;
      quo_r[0]  <= '0;
      pay_r[0]  <= in_pay;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int K = QW - 1 - j;
    logic [DW:0] s;
    logic [DW:0] diff;
    logic        ge;

    assign s    = {rem_r[j], bits_r[j][K]};
    assign diff = s - {1'b0, div_r[j]};
    assign ge   = (s >= {1'b0, div_r[j]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (en) begin
        vld_r[j+1] <= vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1]  <= ge ? diff[DW-1:0] : s[DW-1:0];
        bits_r[j+1] <= bits_r[j];
        div_r[j+1]  <= div_r[j];
        quo_r[j+1]  <= quo_r[j] | (QW'(ge) << K);
        pay_r[j+1]  <= pay_r[j];
      end
    end
  end

  assign out_vld = vld_r[QW];
  assign out_quo = quo_r[QW];
  assign out_pay = pay_r[QW];

endmodule
`default_nettype wire

[tb/tb_color_gradient_keyframe_eval_top.sv]
// Testbench for the keyframe colour ramp: directed and random key loads and evaluations checked on the fly.
`timescale 1ns / 1ps
module tb_color_gradient_keyframe_eval_top;

  localparam int NKEYS = 16;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    cgk_pkg::action_t act;
    logic [3:0]  idx;
    logic [16:0] ktime;
    logic [31:0] kmin;
    logic [31:0] kmax;
    logic [23:0] age;
    logic [23:0] life;
    logic [16:0] rmix;
  } ramp_req_t;

  typedef struct {
    logic [31:0] colour;
    logic        hit;
  } ramp_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [cgk_pkg::IN_DW-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [cgk_pkg::OUT_DW-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  color_gradient_keyframe_eval_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // shadow of the block's state
  logic [16:0] tbl_time [NKEYS];
  logic [31:0] tbl_min [NKEYS];
  logic [31:0] tbl_max [NKEYS];
  logic [4:0]  key_cnt = 5'd0;
  logic [31:0] dflt_colour = 32'hFFFF_FFFF;

  ramp_req_t req_q[$];
  ramp_res_t colour_due[$];
  ramp_req_t cur;
  int errors = 0;
  int phase = 0;
  int src_idle = 0;
  int snk_idle = 0;
  int hold_cnt = 0;
  bit held = 1'b0;
  int quiet = 0;

  function automatic ramp_res_t ramp_colour(ramp_req_t r);
    logic [63:0] t, from, to, d, bk, rm, a0, a1, b0, b1, mn, mx, v;
    int cnt;
    ramp_res_t res;
    cnt = (key_cnt > NKEYS) ? NKEYS : int'(key_cnt);
    res.colour = dflt_colour;
    res.hit = 1'b0;
    rm = (r.rmix > 17'd65536) ? 64'd65536 : 64'(r.rmix);
    if (r.life != 0 && cnt >= 2) begin
      t = (64'(r.age) << 16) / 64'(r.life);
      if (t > 64'd131072) t = 64'd131072;
      for (int n = 0; n + 1 < cnt; n++) begin
        from = 64'(tbl_time[n]);
        to = 64'(tbl_time[n + 1]);
        if (!res.hit && t >= from && t <= to) begin
          d = to - from;
          bk = 64'd0;
          if (d > 64'd65) bk = ((t - from) << 16) / d;
          if (bk > 64'd65536) bk = 64'd65536;
          res.hit = 1'b1;
          res.colour = '0;
          for (int sh = 0; sh < 32; sh += 8) begin
            a0 = 64'(tbl_min[n][sh +: 8]);
            a1 = 64'(tbl_min[n + 1][sh +: 8]);
            b0 = 64'(tbl_max[n][sh +: 8]);
            b1 = 64'(tbl_max[n + 1][sh +: 8]);
            mn = a0 * (64'd65536 - bk) + a1 * bk;
            mx = b0 * (64'd65536 - bk) + b1 * bk;
            v = (mn * (64'd65536 - rm) + mx * rm + 64'h8000_0000) >> 32;
            if (v > 64'd255) v = 64'd255;
            res.colour[sh +: 8] = v[7:0];
          end
        end
      end
    end
    return res;
  endfunction

  // driver: take the next request once the current one has gone
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (cur.act == cgk_pkg::ACT_WRITE) begin
          tbl_time[cur.idx] = cur.ktime;
          tbl_min[cur.idx] = cur.kmin;
          tbl_max[cur.idx] = cur.kmax;
        end else begin
          colour_due.insert(colour_due.size(), ramp_colour(cur));
        end
      end
      if (!in_tvalid || in_tready) begin
        if (req_q.size() > 0 && $urandom_range(99) >= src_idle) begin
          cur = req_q.pop_front();
          in_tuser <= cur.act;
          in_tdata <= {2'b0, cur.rmix, cur.life, cur.age, cur.kmax, cur.kmin, cur.ktime, cur.idx};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    ramp_res_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (colour_due.size() == 0) begin
          $error("unexpected result colour=%h hit=%b", out_tdata[31:0], out_tdata[32]);
          errors++;
        end else begin
          e = colour_due.pop_front();
          if (out_tdata[31:0] !== e.colour) begin
            $error("colour: expected %h, got %h", e.colour, out_tdata[31:0]);
            errors++;
          end
          if (out_tdata[32] !== e.hit) begin
            $error("hit: expected %b, got %b", e.hit, out_tdata[32]);
            errors++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_tready <= 1'b0;
      end else if (phase == 8 && !held && out_tvalid) begin
        // long hold-off so the pipeline fills and backs up the input
        held <= 1'b1;
        hold_cnt <= 600;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= snk_idle);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_key(input int idx, input int tm, input logic [31:0] mn,
                          input logic [31:0] mx);
    ramp_req_t r;
    r.act = cgk_pkg::ACT_WRITE;
    r.idx = idx[3:0];
    r.ktime = tm[16:0];
    r.kmin = mn;
    r.kmax = mx;
    r.age = 24'($urandom);
    r.life = 24'($urandom);
    r.rmix = 17'($urandom);
    req_q.insert(req_q.size(), r);
  endtask

  task automatic send_eval(input logic [23:0] age, input logic [23:0] life,
                           input logic [16:0] rmix);
    ramp_req_t r;
    r.act = cgk_pkg::ACT_EVAL;
    r.idx = 4'($urandom);
    r.ktime = 17'($urandom);
    r.kmin = $urandom;
    r.kmax = $urandom;
    r.age = age;
    r.life = life;
    r.rmix = rmix;
    req_q.insert(req_q.size(), r);
  endtask

  task automatic set_cfg(input logic idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == cgk_pkg::CFG_KEY_COUNT) key_cnt = val[4:0];
    else dflt_colour = val;
  endtask

  task automatic wait_idle();
    while (req_q.size() > 0 || in_tvalid || colour_due.size() > 0) @(posedge clk);
    // key writes give no result and may still be in flight
    repeat (50) @(posedge clk);
  endtask

  // sorted key times with a few zero-length and very short segments
  task automatic load_sorted_keys();
    int tm;
    tm = $urandom_range(0, 2000);
    for (int n = 0; n < NKEYS; n++) begin
      if (n > 0) tm += ($urandom_range(7) == 0) ? $urandom_range(0, 65) : $urandom_range(66, 9000);
      if (tm > 65536) tm = 65536;
      send_key(n, tm, $urandom, $urandom);
    end
  endtask

  initial begin
    int kc[10] = '{16, 2, 0, 1, 16, 5, 9, 16, 3, 12};
    logic [23:0] life, age;
    logic [16:0] rmix;
    logic [31:0] dc;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    set_cfg(cgk_pkg::CFG_KEY_COUNT, 32'd16);
    set_cfg(cgk_pkg::CFG_DEFAULT, 32'h0000_0000);
    @(posedge clk) cfg_we <= 1'b0;
    // directed: fill every slot first so no unwritten key is ever read
    send_key(0, 0, 32'h0000_0000, 32'hFFFF_FFFF);
    send_key(1, 30, 32'hFFFF_FFFF, 32'h0000_0000);
    send_key(2, 20000, 32'h80FF_00AA, 32'h1234_5678);
    send_key(3, 10000, 32'hFF00_FF00, 32'h00FF_00FF);
    for (int n = 4; n < 15; n++) send_key(n, 30000 + (n - 4) * 3200, $urandom, $urandom);
    send_key(15, 65536, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_eval(24'd0, 24'd0, 17'd0);                    // zero lifetime
    send_eval(24'd0, 24'd100, 17'd0);                  // first key exactly
    send_eval(24'd1, 24'd65536, 17'd65536);            // inside short segment
    send_eval(24'd15000, 24'd65536, 17'd32768);        // reversed segment skipped
    send_eval(24'd100, 24'd100, 17'd65536);            // last key exactly
    send_eval(24'hFFFFFF, 24'd1, 17'd131071);          // clamped time, mix saturated
    send_eval(24'hFFFFFF, 24'hFFFFFF, 17'd1);
    send_eval(24'd40000, 24'd65536, 17'd65535);
    wait_idle();

    for (phase = 0; phase < 10; phase++) begin
      if (phase < 4) begin
        src_idle = 7; snk_idle = 84;
      end else if (phase < 7) begin
        src_idle = 84; snk_idle = 7;
      end else begin
        src_idle = 0; snk_idle = 0;
      end
      dc = (phase % 3 == 0) ? 32'hFFFF_FFFF : (phase % 3 == 1) ? 32'h0 : $urandom;
      set_cfg(cgk_pkg::CFG_KEY_COUNT, kc[phase]);
      set_cfg(cgk_pkg::CFG_DEFAULT, dc);
      @(posedge clk) cfg_we <= 1'b0;
      load_sorted_keys();
      for (int i = 0; i < 150; i++) begin
        if ($urandom_range(9) == 0) begin
          send_key($urandom_range(0, 15), ($urandom_range(3) == 0) ? $urandom_range(0, 131071)
                   : $urandom_range(0, 65536), $urandom, $urandom);
        end else begin
          case ($urandom_range(3))
            0: life = 24'($urandom_range(1, 255));
            1: life = 24'($urandom);
            default: life = 24'($urandom_range(1, 200000));
          endcase
          if ($urandom_range(49) == 0) life = 24'd0;
          if ($urandom_range(9) == 0) age = 24'($urandom);
          else age = 24'(($urandom_range(0, 1000) * 64'(life) * 5) / 4000);
          rmix = ($urandom_range(4) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
          send_eval(age, life, rmix);
        end
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
